@@ hw/rtl/lcdri_pkg.sv @@
// Shared types and constants of the LCD controller register interface.
`timescale 1ns / 1ps
package lcdri_pkg;

  // Host bus operations carried by the opcode field.
  localparam logic [2:0] OP_TICK      = 3'd0;
  localparam logic [2:0] OP_CTRL_WR   = 3'd1;
  localparam logic [2:0] OP_DATA_WR   = 3'd2;
  localparam logic [2:0] OP_STATUS_RD = 3'd3;
  localparam logic [2:0] OP_DATA_RD   = 3'd4;

  // Instruction codes latched by a control write.
  localparam logic [7:0] INS_MODE     = 8'd0;
  localparam logic [7:0] INS_PITCH    = 8'd1;
  localparam logic [7:0] INS_CHARS    = 8'd2;
  localparam logic [7:0] INS_DIVS     = 8'd3;
  localparam logic [7:0] INS_CLINE    = 8'd4;
  localparam logic [7:0] INS_START_LO = 8'd8;
  localparam logic [7:0] INS_START_HI = 8'd9;
  localparam logic [7:0] INS_CUR_LO   = 8'd10;
  localparam logic [7:0] INS_CUR_HI   = 8'd11;
  localparam logic [7:0] INS_RAM_WR   = 8'd12;
  localparam logic [7:0] INS_BIT_CLR  = 8'd14;
  localparam logic [7:0] INS_BIT_SET  = 8'd15;

  // Execution times in ticks.
  localparam logic [5:0] BUSY_SHORT = 6'd4;
  localparam logic [5:0] BUSY_RAM   = 6'd6;
  localparam logic [5:0] BUSY_BIT   = 6'd36;

  localparam logic [3:0] HPITCH_RESET = 4'd6;

  localparam int QUEUE_DEPTH = 2;

  // What the back end has to do for one item.
  typedef enum logic [3:0] {
    K_NONE,
    K_TICK,
    K_STATUS,
    K_DATA_RD,
    K_MODE,
    K_PITCH,
    K_CHARS,
    K_DIVS,
    K_CLINE,
    K_START_LO,
    K_START_HI,
    K_CUR_LO,
    K_CUR_HI,
    K_RAM_WR,
    K_BIT_CLR,
    K_BIT_SET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ hw/rtl/lcdri_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module lcdri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/lcdri_front.sv @@
// Front end: latches the instruction code and classifies each accepted item.
`timescale 1ns / 1ps
module lcdri_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [2:0]        opcode,
  input  logic [7:0]        bus_data,
  output logic              push,
  output lcdri_pkg::cmd_t   cmd
);
  import lcdri_pkg::*;

  logic [7:0] instruction_code;
  cmd_kind_t  wr_kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      instruction_code <= INS_MODE;
    end else if (accept && opcode == OP_CTRL_WR) begin
      instruction_code <= bus_data;
    end
  end

  // A data write is resolved here against the code latched so far, so items
  // already queued keep the instruction that was current when they arrived.
  always_comb begin
    unique case (instruction_code)
      INS_MODE:     wr_kind = K_MODE;
      INS_PITCH:    wr_kind = K_PITCH;
      INS_CHARS:    wr_kind = K_CHARS;
      INS_DIVS:     wr_kind = K_DIVS;
      INS_CLINE:    wr_kind = K_CLINE;
      INS_START_LO: wr_kind = K_START_LO;
      INS_START_HI: wr_kind = K_START_HI;
      INS_CUR_LO:   wr_kind = K_CUR_LO;
      INS_CUR_HI:   wr_kind = K_CUR_HI;
      INS_RAM_WR:   wr_kind = K_RAM_WR;
      INS_BIT_CLR:  wr_kind = K_BIT_CLR;
      INS_BIT_SET:  wr_kind = K_BIT_SET;
      default:      wr_kind = K_NONE;
    endcase
  end

  always_comb begin
    cmd.data = bus_data;
    unique case (opcode)
      OP_TICK:      cmd.kind = K_TICK;
      OP_DATA_WR:   cmd.kind = wr_kind;
      OP_STATUS_RD: cmd.kind = K_STATUS;
      OP_DATA_RD:   cmd.kind = K_DATA_RD;
      default:      cmd.kind = K_NONE;
    endcase
  end

  assign push = accept;

endmodule

@@ hw/rtl/lcdri_queue.sv @@
// Two-entry queue of classified items between the front and back ends.
`timescale 1ns / 1ps
module lcdri_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcdri_pkg::cmd_t     push_cmd,
  input  logic                pop,
  output lcdri_pkg::cmd_t     head_cmd,
  output lcdri_pkg::q_stat_t  stat
);
  import lcdri_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  cmd_t                entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_BITS'(QUEUE_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && stat.full)) else $error("item pushed into a full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && stat.empty)) else $error("item popped from an empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(QUEUE_DEPTH)) else $error("queue count out of range");
`endif

endmodule

@@ hw/rtl/lcdri_back.sv @@
// Back end: clears the video RAM, then carries out queued items one by one.
`timescale 1ns / 1ps
module lcdri_back #(
  parameter int RAM_ADDR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  lcdri_pkg::cmd_t     head_cmd,
  input  lcdri_pkg::q_stat_t  q_stat,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output logic [7:0]          read_data,
  output logic                busy_res,
  output logic [7:0]          mode_bits,
  output logic [3:0]          horiz_pitch,
  output logic [4:0]          vert_pitch,
  output logic [7:0]          chars_per_line,
  output logic [7:0]          time_divisions,
  output logic [7:0]          cursor_line,
  output logic [15:0]         display_start,
  output logic [15:0]         cursor_address
);
  import lcdri_pkg::*;

  localparam int RAM_DEPTH = 1 << RAM_ADDR_BITS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW
  } state_t;

  state_t                   state;
  cmd_t                     held_cmd;
  logic [RAM_ADDR_BITS-1:0] clear_addr;
  logic [7:0]               read_prefetch;
  logic [5:0]               busy_remaining;
  logic                     ram_we;
  logic [RAM_ADDR_BITS-1:0] ram_addr;
  logic [7:0]               ram_wdata;
  logic [7:0]               ram_rdata;
  logic [7:0]               bit_mask;
  logic [7:0]               rmw_data;
  logic                     rmw_item;

  lcdri_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign pop      = (state == S_IDLE) && !q_stat.empty;
  assign clearing = (state == S_CLEAR);
  assign busy_res = (busy_remaining != '0);
  assign bit_mask = 8'd1 << held_cmd.data[2:0];
  assign rmw_data = (held_cmd.kind == K_BIT_CLR) ? (ram_rdata & ~bit_mask)
                                                 : (ram_rdata | bit_mask);
  // Items that read the video RAM pass through S_RMW before they finish.
  assign rmw_item = (head_cmd.kind == K_DATA_RD) || (head_cmd.kind == K_BIT_CLR) ||
                    (head_cmd.kind == K_BIT_SET);

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = cursor_address[RAM_ADDR_BITS-1:0];
    ram_wdata = head_cmd.data;
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clear_addr;
        ram_wdata = 8'h00;
      end
      S_IDLE: begin
        ram_we = pop && (head_cmd.kind == K_RAM_WR);
      end
      S_RMW: begin
        ram_we    = (held_cmd.kind != K_DATA_RD);
        ram_wdata = rmw_data;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clear_addr     <= '0;
      done           <= 1'b0;
      read_data      <= 8'h00;
      read_prefetch  <= 8'h00;
      busy_remaining <= '0;
      mode_bits      <= 8'h00;
      horiz_pitch    <= HPITCH_RESET;
      vert_pitch     <= '0;
      chars_per_line <= 8'h00;
      time_divisions <= 8'h00;
      cursor_line    <= 8'h00;
      display_start  <= 16'h0000;
      cursor_address <= 16'h0000;
    end else begin
      done <= ((state == S_IDLE) && pop && !rmw_item) || (state == S_RMW);
      unique case (state)
        S_CLEAR: begin
          clear_addr <= clear_addr + 1'b1;
          if (clear_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (pop) begin
            held_cmd  <= head_cmd;
            read_data <= (head_cmd.kind == K_STATUS) ? {busy_res, 7'b0} : 8'h00;
            case (head_cmd.kind) inside
              K_TICK: begin
                if (busy_remaining != '0) begin
                  busy_remaining <= busy_remaining - 6'd1;
                end
              end
              K_DATA_RD, K_BIT_CLR, K_BIT_SET: begin
                // The RAM byte arrives next cycle; the result waits for it.
                state <= S_RMW;
              end
              K_MODE: begin
                mode_bits      <= head_cmd.data;
                busy_remaining <= BUSY_SHORT;
              end
              K_PITCH: begin
                horiz_pitch    <= {1'b0, head_cmd.data[2:0]} + 4'd1;
                vert_pitch     <= {1'b0, head_cmd.data[7:4]} + 5'd1;
                busy_remaining <= BUSY_SHORT;
              end
              K_CHARS: begin
                chars_per_line <= {1'b0, head_cmd.data[6:0]} + 8'd1;
                busy_remaining <= BUSY_SHORT;
              end
              K_DIVS: begin
                time_divisions <= {1'b0, head_cmd.data[6:0]} + 8'd1;
                busy_remaining <= BUSY_SHORT;
              end
              K_CLINE: begin
                cursor_line    <= {1'b0, head_cmd.data[6:0]} + 8'd1;
                busy_remaining <= BUSY_SHORT;
              end
              K_START_LO: begin
                display_start[7:0] <= head_cmd.data;
                busy_remaining     <= BUSY_SHORT;
              end
              K_START_HI: begin
                display_start[15:8] <= head_cmd.data;
                busy_remaining      <= BUSY_SHORT;
              end
              K_CUR_LO: begin
                // Writing a low byte below 0x80 over one at or above it
                // carries into the high byte.
                if (cursor_address[7] && !head_cmd.data[7]) begin
                  cursor_address <= {cursor_address[15:8] + 8'd1, head_cmd.data};
                end else begin
                  cursor_address <= {cursor_address[15:8], head_cmd.data};
                end
                busy_remaining <= BUSY_SHORT;
              end
              K_CUR_HI: begin
                cursor_address[15:8] <= head_cmd.data;
                busy_remaining       <= BUSY_SHORT;
              end
              K_RAM_WR: begin
                cursor_address <= cursor_address + 16'd1;
                busy_remaining <= BUSY_RAM;
              end
              default: ;
            endcase
          end
        end
        S_RMW: begin
          if (held_cmd.kind == K_DATA_RD) begin
            read_data     <= read_prefetch;
            read_prefetch <= ram_rdata;
          end else begin
            busy_remaining <= BUSY_BIT;
          end
          cursor_address <= cursor_address + 16'd1;
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_result_clearing: assert property (@(posedge clk) disable iff (rst)
    done |-> state != S_CLEAR) else $error("result during RAM clearing pass");
  a_rmw_result: assert property (@(posedge clk) disable iff (rst)
    state == S_RMW |=> done && state == S_IDLE)
    else $error("RAM access item did not finish in one extra cycle");
  a_busy_range: assert property (@(posedge clk) disable iff (rst)
    busy_remaining <= BUSY_BIT) else $error("busy count above longest time");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> !done || state == S_IDLE) else $error("pop outside idle state");
`endif

endmodule

@@ hw/rtl/lcd_controller_register_interface.sv @@
// Top level of the LCD controller register interface.
//
// An item (opcode, bus_data) is accepted at a rising edge with start high and
// busy low. Each item gives one result: done is high for exactly one cycle,
// with read_data and the register view ports valid in that cycle; the
// receiver cannot hold results off and must take it then.
// A result is registered by the back end once the item has left the queue;
// a data read, bit set or bit clear first passes the S_RMW state, reading
// the video RAM through its registered read port and, for the bit
// operations, writing it back. The back end finishes one item per cycle
// while the queue holds items and it is not in S_RMW; the two-entry queue
// between front and back end raises busy when full.
// After reset all 2**RAM_ADDR_BITS bytes of the video RAM are cleared one
// byte per cycle; busy stays high until the pass completes.
// Reset also restores all controller registers, horizontal pitch to six.
`timescale 1ns / 1ps
module lcd_controller_register_interface #(
  parameter int RAM_ADDR_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [2:0]  opcode,
  input  logic [7:0]  bus_data,
  output logic        busy,
  output logic        done,
  output logic [7:0]  read_data,
  output logic        busy_res,
  output logic [7:0]  mode_bits,
  output logic [3:0]  horiz_pitch,
  output logic [4:0]  vert_pitch,
  output logic [7:0]  chars_per_line,
  output logic [7:0]  time_divisions,
  output logic [7:0]  cursor_line,
  output logic [15:0] display_start,
  output logic [15:0] cursor_address
);
  import lcdri_pkg::*;

  logic    accept;
  logic    push;
  logic    pop;
  logic    clearing;
  cmd_t    push_cmd;
  cmd_t    head_cmd;
  q_stat_t q_stat;

  assign busy   = clearing || q_stat.full;
  assign accept = start && !busy;

  lcdri_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .opcode   (opcode),
    .bus_data (bus_data),
    .push     (push),
    .cmd      (push_cmd)
  );

  lcdri_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  lcdri_back #(
    .RAM_ADDR_BITS (RAM_ADDR_BITS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .head_cmd       (head_cmd),
    .q_stat         (q_stat),
    .pop            (pop),
    .clearing       (clearing),
    .done           (done),
    .read_data      (read_data),
    .busy_res       (busy_res),
    .mode_bits      (mode_bits),
    .horiz_pitch    (horiz_pitch),
    .vert_pitch     (vert_pitch),
    .chars_per_line (chars_per_line),
    .time_divisions (time_divisions),
    .cursor_line    (cursor_line),
    .display_start  (display_start),
    .cursor_address (cursor_address)
  );

endmodule
